>>> hw/rtl/i2cmrt_pkg.sv
// Package for the I2C master register transfer unit: item types and constants.
`timescale 1ns / 1ps
`default_nettype none

package i2cmrt_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] device_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] write_data;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       write_taken;
    logic [7:0] read_data;
    logic       read_valid;
    logic       done_res;
    logic       status;
  } rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/i2cmrt_seq.sv
// Bus phase sequencer: transfer state and the step logic for one tick item.
`timescale 1ns / 1ps
`default_nettype none

module i2cmrt_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire i2cmrt_pkg::cmd_t  item,
  input  wire logic [7:0]        ack_timeout,
  output i2cmrt_pkg::rsp_t       result
);

  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_ST1   = 5'd1,
    PH_ST2   = 5'd2,
    PH_ST3   = 5'd3,
    PH_BLO   = 5'd4,
    PH_BHI   = 5'd5,
    PH_ALO   = 5'd6,
    PH_AHI   = 5'd7,
    PH_RS0   = 5'd8,
    PH_DLOAD = 5'd9,
    PH_RLO   = 5'd10,
    PH_RHI   = 5'd11,
    PH_MLO   = 5'd12,
    PH_MHI   = 5'd13,
    PH_P1    = 5'd14,
    PH_P2    = 5'd15,
    PH_P3    = 5'd16
  } phase_t;

  typedef enum logic [1:0] {
    STG_ADDR  = 2'd0,
    STG_REG   = 2'd1,
    STG_RADDR = 2'd2,
    STG_DATA  = 2'd3
  } stage_t;

  phase_t     phase, phase_next;
  stage_t     byte_stage, byte_stage_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] ack_wait_count, ack_wait_count_next;
  logic [7:0] held_device_addr, held_device_addr_next;
  logic [7:0] held_reg_addr, held_reg_addr_next;
  logic       is_read, is_read_next;
  logic       abort_flag, abort_flag_next;

  logic [8:0] wait_inc;
  logic       ack_fail;
  logic       do_after;

  always_comb begin
    phase_next            = phase;
    byte_stage_next       = byte_stage;
    bit_index_next        = bit_index;
    shift_byte_next       = shift_byte;
    bytes_left_next       = bytes_left;
    ack_wait_count_next   = ack_wait_count;
    held_device_addr_next = held_device_addr;
    held_reg_addr_next    = held_reg_addr;
    is_read_next          = is_read;
    abort_flag_next       = abort_flag;
    do_after              = 1'b0;
    wait_inc              = {1'b0, ack_wait_count} + 9'd1;
    ack_fail              = wait_inc > {1'b0, ack_timeout};

    result             = '0;
    result.scl_level   = 1'b1;
    result.sda_level   = 1'b1;
    result.sda_drive   = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (item.operation == i2cmrt_pkg::OP_WRITE ||
            item.operation == i2cmrt_pkg::OP_READ) begin
          held_device_addr_next = item.device_addr;
          held_reg_addr_next    = item.reg_addr;
          bytes_left_next       = item.byte_count;
          is_read_next          = (item.operation == i2cmrt_pkg::OP_READ);
          shift_byte_next       = item.device_addr;
          byte_stage_next       = STG_ADDR;
          abort_flag_next       = 1'b0;
          phase_next            = PH_ST1;
        end
      end
      PH_RS0: begin
        result.scl_level = 1'b0;
        result.sda_drive = 1'b1;
        phase_next       = PH_ST1;
      end
      PH_ST1: begin
        result.sda_drive = 1'b1;
        phase_next       = PH_ST2;
      end
      PH_ST2: begin
        result.sda_level = 1'b0;
        result.sda_drive = 1'b1;
        phase_next       = PH_ST3;
      end
      PH_ST3: begin
        result.scl_level = 1'b0;
        result.sda_level = 1'b0;
        result.sda_drive = 1'b1;
        bit_index_next   = 3'd0;
        phase_next       = PH_BLO;
      end
      PH_DLOAD: begin
        shift_byte_next    = item.write_data;
        result.write_taken = 1'b1;
        bytes_left_next    = bytes_left - 8'd1;
        bit_index_next     = 3'd0;
        result.scl_level   = 1'b0;
        result.sda_level   = item.write_data[7];
        result.sda_drive   = 1'b1;
        phase_next         = PH_BHI;
      end
      PH_BLO: begin
        result.scl_level = 1'b0;
        result.sda_level = shift_byte[7];
        result.sda_drive = 1'b1;
        phase_next       = PH_BHI;
      end
      PH_BHI: begin
        result.sda_level = shift_byte[7];
        result.sda_drive = 1'b1;
        shift_byte_next  = {shift_byte[6:0], 1'b0};
        bit_index_next   = bit_index + 3'd1;
        phase_next       = (bit_index == 3'd7) ? PH_ALO : PH_BLO;
      end
      PH_ALO: begin
        result.scl_level    = 1'b0;
        ack_wait_count_next = 8'd0;
        phase_next          = PH_AHI;
      end
      PH_AHI: begin
        if (!item.sda_in) begin
          do_after = 1'b1;
        end else begin
          ack_wait_count_next = wait_inc[8] ? 8'hFF : wait_inc[7:0];
          if (ack_fail) begin
            if (byte_stage == STG_ADDR || byte_stage == STG_DATA) begin
              abort_flag_next = 1'b1;
              phase_next      = PH_P1;
            end else begin
              do_after = 1'b1;
            end
          end
        end
      end
      PH_RLO: begin
        result.scl_level = 1'b0;
        phase_next       = PH_RHI;
      end
      PH_RHI: begin
        shift_byte_next = {shift_byte[6:0], item.sda_in};
        bit_index_next  = bit_index + 3'd1;
        if (bit_index == 3'd7) begin
          result.read_valid = 1'b1;
          result.read_data  = {shift_byte[6:0], item.sda_in};
          bytes_left_next   = bytes_left - 8'd1;
          phase_next        = PH_MLO;
        end else begin
          phase_next = PH_RLO;
        end
      end
      PH_MLO: begin
        result.scl_level = 1'b0;
        result.sda_level = (bytes_left == 8'd0);
        result.sda_drive = 1'b1;
        phase_next       = PH_MHI;
      end
      PH_MHI: begin
        result.sda_level = (bytes_left == 8'd0);
        result.sda_drive = 1'b1;
        if (bytes_left == 8'd0) begin
          abort_flag_next = 1'b0;
          phase_next      = PH_P1;
        end else begin
          phase_next = PH_RLO;
        end
      end
      PH_P1: begin
        result.scl_level = 1'b0;
        result.sda_level = 1'b0;
        result.sda_drive = 1'b1;
        phase_next       = PH_P2;
      end
      PH_P2: begin
        result.sda_level = 1'b0;
        result.sda_drive = 1'b1;
        phase_next       = PH_P3;
      end
      PH_P3: begin
        result.sda_drive = 1'b1;
        result.done_res  = 1'b1;
        result.status    = abort_flag;
        abort_flag_next  = 1'b0;
        phase_next       = PH_IDLE;
      end
      default: begin
        result.sda_drive = 1'b1;
        result.done_res  = 1'b1;
        result.status    = abort_flag;
        abort_flag_next  = 1'b0;
        phase_next       = PH_IDLE;
      end
    endcase

    // acknowledge accepted (or ignored): move on to the next byte, or to the stop when none is left
    if (do_after) begin
      bit_index_next = 3'd0;
      unique case (byte_stage)
        STG_ADDR: begin
          shift_byte_next = held_reg_addr;
          byte_stage_next = STG_REG;
          phase_next      = PH_BLO;
        end
        STG_REG: begin
          if (is_read) begin
            shift_byte_next = held_device_addr | 8'h01;
            byte_stage_next = STG_RADDR;
            phase_next      = PH_RS0;
          end else if (bytes_left == 8'd0) begin
            abort_flag_next = 1'b0;
            phase_next      = PH_P1;
          end else begin
            byte_stage_next = STG_DATA;
            phase_next      = PH_DLOAD;
          end
        end
        STG_RADDR: begin
          if (bytes_left == 8'd0) begin
            abort_flag_next = 1'b0;
            phase_next      = PH_P1;
          end else begin
            phase_next = PH_RLO;
          end
        end
        default: begin
          if (bytes_left == 8'd0) begin
            abort_flag_next = 1'b0;
            phase_next      = PH_P1;
          end else begin
            phase_next = PH_DLOAD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      byte_stage       <= STG_ADDR;
      bit_index        <= 3'd0;
      shift_byte       <= 8'd0;
      bytes_left       <= 8'd0;
      ack_wait_count   <= 8'd0;
      held_device_addr <= 8'd0;
      held_reg_addr    <= 8'd0;
      is_read          <= 1'b0;
      abort_flag       <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      byte_stage       <= byte_stage_next;
      bit_index        <= bit_index_next;
      shift_byte       <= shift_byte_next;
      bytes_left       <= bytes_left_next;
      ack_wait_count   <= ack_wait_count_next;
      held_device_addr <= held_device_addr_next;
      held_reg_addr    <= held_reg_addr_next;
      is_read          <= is_read_next;
      abort_flag       <= abort_flag_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/i2c_master_register_transfer_unit.sv
// Top level of the I2C master register transfer unit: item registers and config.
// Throughput: one item per cycle unless rsp_stall holds the result; the sequencer state advances once per item.
// Items pass an input register, the sequencer step logic and a result register.
// Reset: sequencer goes idle with all state zero, ack_timeout returns to 250.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_register_transfer_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_stall,
  input  wire i2cmrt_pkg::cmd_t  cmd,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output i2cmrt_pkg::rsp_t       rsp,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_data
);

  logic              held_valid;
  i2cmrt_pkg::cmd_t  held_item;
  logic [7:0]        ack_timeout;
  logic              out_free;
  logic              advance;
  i2cmrt_pkg::rsp_t  step_result;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign advance   = held_valid && out_free;
  assign cmd_stall = held_valid && !out_free;
  assign cfg_ready = 1'b1;

  i2cmrt_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (held_item),
    .ack_timeout (ack_timeout),
    .result      (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= i2cmrt_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ack_timeout <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!cmd_stall) begin
      held_valid <= cmd_valid;
    end
    if (cmd_valid && !cmd_stall) begin
      held_item <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= held_valid;
    end
    if (advance) begin
      rsp <= step_result;
    end
  end

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench for the I2C master register transfer unit: predicted pin trace and checks.
`timescale 1ns / 1ps

module tb;

  typedef enum logic [4:0] {
    SQ_IDLE, SQ_ST1, SQ_ST2, SQ_ST3, SQ_BLO, SQ_BHI, SQ_ALO, SQ_AHI, SQ_RS0,
    SQ_DLOAD, SQ_RLO, SQ_RHI, SQ_MLO, SQ_MHI, SQ_P1, SQ_P2, SQ_P3
  } seq_ph_t;

  typedef enum logic [1:0] {BYTE_DEV, BYTE_REG, BYTE_RDEV, BYTE_DATA} byte_stage_t;

  typedef enum {ACK_RANDOM, NACK_ALL, NACK_AFTER_ADDR} ack_mode_t;

  typedef struct {
    i2cmrt_pkg::op_t op;
    logic [7:0]      dev;
    logic [7:0]      regad;
    logic [7:0]      cnt;
    ack_mode_t       mode;
  } xfer_plan_t;

  class i2c_pin_scoreboard;
    i2cmrt_pkg::rsp_t pins_q[$];
    int          errors;
    logic [7:0]  ack_limit;
    seq_ph_t     ph;
    byte_stage_t stage;
    logic [2:0]  bit_cnt;
    logic [7:0]  shreg, left, ack_cnt, dev_q, reg_q;
    logic        rd, aborted;

    function new();
      errors = 0;
      ack_limit = i2cmrt_pkg::ACK_TIMEOUT_RESET;
      ph = SQ_IDLE;
      stage = BYTE_DEV;
      bit_cnt = '0;
      shreg = '0;
      left = '0;
      ack_cnt = '0;
      dev_q = '0;
      reg_q = '0;
      rd = 1'b0;
      aborted = 1'b0;
    endfunction

    function void send_stop(logic err);
      aborted = err;
      ph = SQ_P1;
    endfunction

    function void finish_byte();
      bit_cnt = '0;
      case (stage)
        BYTE_DEV: begin
          shreg = reg_q;
          stage = BYTE_REG;
          ph = SQ_BLO;
        end
        BYTE_REG: begin
          if (rd) begin
            shreg = dev_q | 8'h01;
            stage = BYTE_RDEV;
            ph = SQ_RS0;
          end else if (left == 8'd0) begin
            send_stop(1'b0);
          end else begin
            stage = BYTE_DATA;
            ph = SQ_DLOAD;
          end
        end
        BYTE_RDEV: begin
          if (left == 8'd0) send_stop(1'b0);
          else ph = SQ_RLO;
        end
        default: begin
          if (left == 8'd0) send_stop(1'b0);
          else ph = SQ_DLOAD;
        end
      endcase
    endfunction

    function i2cmrt_pkg::rsp_t step_bus(i2cmrt_pkg::cmd_t c);
      i2cmrt_pkg::rsp_t r;
      logic [8:0] nxt;
      r = '0;
      r.scl_level = 1'b1;
      r.sda_level = 1'b1;
      case (ph)
        SQ_IDLE: begin
          if (c.operation == i2cmrt_pkg::OP_WRITE || c.operation == i2cmrt_pkg::OP_READ) begin
            dev_q = c.device_addr;
            reg_q = c.reg_addr;
            left = c.byte_count;
            rd = (c.operation == i2cmrt_pkg::OP_READ);
            shreg = c.device_addr;
            stage = BYTE_DEV;
            aborted = 1'b0;
            ph = SQ_ST1;
          end
        end
        SQ_RS0: begin
          r.scl_level = 1'b0;
          r.sda_drive = 1'b1;
          ph = SQ_ST1;
        end
        SQ_ST1: begin
          r.sda_drive = 1'b1;
          ph = SQ_ST2;
        end
        SQ_ST2: begin
          r.sda_level = 1'b0;
          r.sda_drive = 1'b1;
          ph = SQ_ST3;
        end
        SQ_ST3: begin
          r.scl_level = 1'b0;
          r.sda_level = 1'b0;
          r.sda_drive = 1'b1;
          bit_cnt = '0;
          ph = SQ_BLO;
        end
        SQ_DLOAD: begin
          shreg = c.write_data;
          r.write_taken = 1'b1;
          left = left - 8'd1;
          bit_cnt = '0;
          r.scl_level = 1'b0;
          r.sda_level = shreg[7];
          r.sda_drive = 1'b1;
          ph = SQ_BHI;
        end
        SQ_BLO: begin
          r.scl_level = 1'b0;
          r.sda_level = shreg[7];
          r.sda_drive = 1'b1;
          ph = SQ_BHI;
        end
        SQ_BHI: begin
          r.sda_level = shreg[7];
          r.sda_drive = 1'b1;
          shreg = shreg << 1;
          bit_cnt = bit_cnt + 3'd1;
          ph = (bit_cnt == 3'd0) ? SQ_ALO : SQ_BLO;
        end
        SQ_ALO: begin
          r.scl_level = 1'b0;
          ack_cnt = '0;
          ph = SQ_AHI;
        end
        SQ_AHI: begin
          if (!c.sda_in) begin
            finish_byte();
          end else begin
            nxt = {1'b0, ack_cnt} + 9'd1;
            ack_cnt = (nxt > 9'd255) ? 8'd255 : nxt[7:0];
            if (nxt > {1'b0, ack_limit}) begin
              if (stage == BYTE_DEV || stage == BYTE_DATA) send_stop(1'b1);
              else finish_byte();
            end
          end
        end
        SQ_RLO: begin
          r.scl_level = 1'b0;
          ph = SQ_RHI;
        end
        SQ_RHI: begin
          shreg = {shreg[6:0], c.sda_in};
          bit_cnt = bit_cnt + 3'd1;
          if (bit_cnt == 3'd0) begin
            r.read_valid = 1'b1;
            r.read_data = shreg;
            left = left - 8'd1;
            ph = SQ_MLO;
          end else begin
            ph = SQ_RLO;
          end
        end
        SQ_MLO: begin
          r.scl_level = 1'b0;
          r.sda_level = (left == 8'd0);
          r.sda_drive = 1'b1;
          ph = SQ_MHI;
        end
        SQ_MHI: begin
          r.sda_level = (left == 8'd0);
          r.sda_drive = 1'b1;
          if (left == 8'd0) send_stop(1'b0);
          else ph = SQ_RLO;
        end
        SQ_P1: begin
          r.scl_level = 1'b0;
          r.sda_level = 1'b0;
          r.sda_drive = 1'b1;
          ph = SQ_P2;
        end
        SQ_P2: begin
          r.sda_level = 1'b0;
          r.sda_drive = 1'b1;
          ph = SQ_P3;
        end
        default: begin
          r.sda_drive = 1'b1;
          r.done_res = 1'b1;
          r.status = aborted;
          aborted = 1'b0;
          ph = SQ_IDLE;
        end
      endcase
      return r;
    endfunction

    function void take_cmd(i2cmrt_pkg::cmd_t c);
      pins_q.push_back(step_bus(c));
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("%0t ERROR: %s", $realtime, msg);
    endtask

    task cmp_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_pins(i2cmrt_pkg::rsp_t got);
      i2cmrt_pkg::rsp_t want;
      if (pins_q.size() == 0) begin
        report_mismatch("result item with nothing expected");
        return;
      end
      want = pins_q.pop_front();
      cmp_field("scl_level", 8'(got.scl_level), 8'(want.scl_level));
      cmp_field("sda_level", 8'(got.sda_level), 8'(want.sda_level));
      cmp_field("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
      cmp_field("write_taken", 8'(got.write_taken), 8'(want.write_taken));
      cmp_field("read_data", got.read_data, want.read_data);
      cmp_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
      cmp_field("done_res", 8'(got.done_res), 8'(want.done_res));
      cmp_field("status", 8'(got.status), 8'(want.status));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cmd_valid = 1'b0;
  logic             cmd_stall;
  i2cmrt_pkg::cmd_t cmd = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  i2cmrt_pkg::rsp_t rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [7:0]       cfg_data = '0;

  i2c_pin_scoreboard sb;
  xfer_plan_t        plan_q[$];
  ack_mode_t         xfer_mode = ACK_RANDOM;
  int                ack_highs = 0;
  int                stall_pct = 0;
  int                hold_left = 0;
  bit                hold_go = 1'b0;

  i2c_master_register_transfer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // result side: checks, random stall, long hold-off on request
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_pins(rsp);
    if (hold_go) begin
      hold_left = 400;
      hold_go = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic add_plan(i2cmrt_pkg::op_t op, logic [7:0] dev, logic [7:0] regad,
                          logic [7:0] cnt, ack_mode_t mode);
    xfer_plan_t p;
    p.op = op;
    p.dev = dev;
    p.regad = regad;
    p.cnt = cnt;
    p.mode = mode;
    plan_q.push_back(p);
  endtask

  // next item, shaped by the predicted sequencer state: slave acks; read data bits are random
  function automatic i2cmrt_pkg::cmd_t next_cmd(bit may_start);
    i2cmrt_pkg::cmd_t c;
    xfer_plan_t       p;
    c.operation = i2cmrt_pkg::OP_TICK;
    c.device_addr = 8'($urandom_range(255));
    c.reg_addr = 8'($urandom_range(255));
    c.byte_count = 8'($urandom_range(255));
    c.write_data = 8'($urandom_range(255));
    c.sda_in = 1'($urandom_range(1));
    if (sb.ph == SQ_IDLE) begin
      if (plan_q.size() != 0) begin
        p = plan_q.pop_front();
        c.operation = p.op;
        c.device_addr = p.dev;
        c.reg_addr = p.regad;
        c.byte_count = p.cnt;
        xfer_mode = p.mode;
      end else if (may_start && $urandom_range(99) < 80) begin
        c.operation = $urandom_range(1) ? i2cmrt_pkg::OP_READ : i2cmrt_pkg::OP_WRITE;
        c.byte_count = ($urandom_range(99) < 10) ? 8'($urandom_range(3, 6))
                                                 : 8'($urandom_range(2));
        xfer_mode = ACK_RANDOM;
        if (sb.ack_limit < 8'd8 && $urandom_range(99) < 15)
          xfer_mode = $urandom_range(1) ? NACK_ALL : NACK_AFTER_ADDR;
      end else begin
        c.operation = $urandom_range(1) ? i2cmrt_pkg::OP_TICK : i2cmrt_pkg::OP_NONE;
      end
    end else begin
      if ($urandom_range(99) < 15)
        c.operation = i2cmrt_pkg::op_t'($urandom_range(i2cmrt_pkg::OP_WRITE,
                                                       i2cmrt_pkg::OP_NONE));
      if (sb.ph == SQ_ALO) begin
        if (xfer_mode == ACK_RANDOM)
          ack_highs = ($urandom_range(99) < 70) ? 0 : $urandom_range(1, 4);
        else if (xfer_mode == NACK_ALL || sb.stage != BYTE_DEV)
          ack_highs = 300;
        else
          ack_highs = 0;
      end
      if (sb.ph == SQ_AHI) begin
        c.sda_in = (ack_highs != 0);
        if (ack_highs != 0) ack_highs--;
      end
    end
    return c;
  endfunction

  task automatic drive_cmds(int n, int idle_pct);
    int sent;
    sent = 0;
    forever begin
      @(posedge clk);
      if (cmd_valid && !cmd_stall) begin
        sb.take_cmd(cmd);
        sent++;
      end
      if (cmd_valid && cmd_stall) continue;
      if (sent >= n && plan_q.size() == 0 && sb.ph == SQ_IDLE) begin
        cmd_valid <= 1'b0;
        break;
      end
      if ($urandom_range(99) < idle_pct) begin
        cmd_valid <= 1'b0;
      end else begin
        cmd_valid <= 1'b1;
        cmd <= next_cmd(sent < n);
      end
    end
  endtask

  task automatic wait_drained();
    while (sb.pins_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_ack_timeout(logic [7:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.ack_limit = v;
  endtask

  initial begin
    int ph_limit[4];
    int ph_idle[4];
    int ph_stall[4];
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // default timeout: idle ops, empty and short transfers, address extremes
    add_plan(i2cmrt_pkg::OP_NONE, 8'h00, 8'h00, 8'h00, ACK_RANDOM);
    add_plan(i2cmrt_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF, ACK_RANDOM);
    add_plan(i2cmrt_pkg::OP_WRITE, 8'h00, 8'h00, 8'h00, ACK_RANDOM);
    add_plan(i2cmrt_pkg::OP_READ, 8'hFE, 8'hFF, 8'h00, ACK_RANDOM);
    add_plan(i2cmrt_pkg::OP_WRITE, 8'hA0, 8'h10, 8'h01, ACK_RANDOM);
    add_plan(i2cmrt_pkg::OP_READ, 8'hFF, 8'h5A, 8'h02, ACK_RANDOM);
    drive_cmds(0, 0);

    // short timeout: address abort, ignored register nack, data abort
    set_ack_timeout(8'd2);
    add_plan(i2cmrt_pkg::OP_WRITE, 8'h42, 8'h01, 8'h01, NACK_ALL);
    add_plan(i2cmrt_pkg::OP_READ, 8'h42, 8'h02, 8'h01, NACK_ALL);
    add_plan(i2cmrt_pkg::OP_WRITE, 8'h3C, 8'h80, 8'hFF, NACK_AFTER_ADDR);
    add_plan(i2cmrt_pkg::OP_READ, 8'h3C, 8'h7F, 8'h02, NACK_AFTER_ADDR);
    drive_cmds(0, 0);

    // saturating count: 256th high sample fails
    set_ack_timeout(8'd255);
    add_plan(i2cmrt_pkg::OP_WRITE, 8'h10, 8'h20, 8'h00, NACK_ALL);
    drive_cmds(0, 0);

    ph_limit = '{0, 3, $urandom_range(4, 254), 255};
    ph_idle = '{0, 56, 0, 27};
    ph_stall = '{0, 0, 56, 27};
    for (int i = 0; i < 4; i++) begin
      set_ack_timeout(8'(ph_limit[i]));
      stall_pct = ph_stall[i];
      if (i == 2) hold_go = 1'b1;
      drive_cmds(100, ph_idle[i]);
    end

    for (int k = 0; k < 2000 && sb.pins_q.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pins_q.size() != 0)
      sb.report_mismatch($sformatf("%0d expected items never arrived", sb.pins_q.size()));
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
